>>> rtl/ssrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssrb_pkg
// shared constants, sequencer states and control struct of the spaced sample
// ring buffer
// ----------------------------------------------------------------------------
package ssrb_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int SAMP_W  = 16;
    localparam int VEC_W   = 3 * SAMP_W;
    localparam int PAY_W   = 3 * VEC_W;
    localparam int ENT_W   = 6;

    localparam logic [IDX_W-1:0]  LAST_IDX        = IDX_W'(DEPTH - 1);
    localparam logic [SAMP_W-1:0] SPACING_RST_VAL = 16'd256;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_READ,
        ST_POP
    } state_t;

    typedef struct packed {
        logic             cap;
        logic             ram_we;
        logic [IDX_W-1:0] ram_waddr;
        logic [IDX_W-1:0] ram_raddr;
        logic             res_vld;
        logic             res_ok;
        logic             res_pop;
        logic [IDX_W-1:0] res_entries;
    } ctrl_t;

endpackage
`default_nettype wire

>>> rtl/ssrb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssrb_ram
// single write port, single registered read port ram
// ----------------------------------------------------------------------------
module ssrb_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 6,
    parameter int WORDS  = 64
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/ssrb_dist.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssrb_dist
// shared distance unit: flags a stored temperature closer than the spacing
// ----------------------------------------------------------------------------
module ssrb_dist (
    input  wire logic signed [ssrb_pkg::SAMP_W-1:0] temp_a,
    input  wire logic signed [ssrb_pkg::SAMP_W-1:0] temp_b,
    input  wire logic        [ssrb_pkg::SAMP_W-1:0] spacing,
    output logic                                    close
);

    logic signed [ssrb_pkg::SAMP_W:0] diff;
    logic        [ssrb_pkg::SAMP_W:0] mag;

    always_comb
    begin
        diff  = (ssrb_pkg::SAMP_W+1)'(temp_a) - (ssrb_pkg::SAMP_W+1)'(temp_b);
        // magnitude never exceeds 16 bits, top bit kept for the compare
        mag   = diff[ssrb_pkg::SAMP_W] ? (ssrb_pkg::SAMP_W+1)'(-diff)
                                       : (ssrb_pkg::SAMP_W+1)'(diff);
        close = mag < {1'b0, spacing};
    end

endmodule
`default_nettype wire

>>> rtl/ssrb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssrb_ctrl
// sequencer and ring pointers: scan, write, read and pop steps
// ----------------------------------------------------------------------------
module ssrb_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            func,
    input  wire logic            close,
    output logic                 busy,
    output ssrb_pkg::ctrl_t      ctrl
);

    ssrb_pkg::state_t state_reg, state_next;

    logic [ssrb_pkg::IDX_W-1:0] head_reg, head_next;
    logic [ssrb_pkg::IDX_W-1:0] tail_reg, tail_next;
    logic [ssrb_pkg::IDX_W-1:0] count_reg, count_next;
    logic [ssrb_pkg::IDX_W-1:0] ptr_reg, ptr_next;
    logic [ssrb_pkg::IDX_W-1:0] iss_reg, iss_next;
    logic [ssrb_pkg::IDX_W-1:0] chk_reg, chk_next;
    logic                       dvld_reg, dvld_next;

    logic                       issue;
    logic                       last_chk;

    function automatic logic [ssrb_pkg::IDX_W-1:0] wrap_inc(
        input logic [ssrb_pkg::IDX_W-1:0] i
    );
        return (i == ssrb_pkg::LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    assign issue    = (iss_reg != count_reg);
    assign last_chk = (chk_reg == count_reg - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssrb_pkg::ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            ptr_reg   <= '0;
            iss_reg   <= '0;
            chk_reg   <= '0;
            dvld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            iss_reg   <= iss_next;
            chk_reg   <= chk_next;
            dvld_reg  <= dvld_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssrb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (func == ssrb_pkg::FUNC_REMOVE)
                    begin
                        state_next = (count_reg == '0) ? ssrb_pkg::ST_IDLE
                                                       : ssrb_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? ssrb_pkg::ST_WRITE
                                                       : ssrb_pkg::ST_SCAN;
                    end
                end
            end
            ssrb_pkg::ST_SCAN:
            begin
                if (dvld_reg)
                begin
                    if (close)
                    begin
                        state_next = ssrb_pkg::ST_IDLE;
                    end
                    else if (last_chk)
                    begin
                        state_next = ssrb_pkg::ST_WRITE;
                    end
                end
            end
            ssrb_pkg::ST_WRITE: state_next = ssrb_pkg::ST_IDLE;
            ssrb_pkg::ST_READ:  state_next = ssrb_pkg::ST_POP;
            ssrb_pkg::ST_POP:   state_next = ssrb_pkg::ST_IDLE;
            default:            state_next = ssrb_pkg::ST_IDLE;
        endcase
    end

    // outputs and pointer updates
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        iss_next   = iss_reg;
        chk_next   = chk_reg;
        dvld_next  = 1'b0;
        busy       = 1'b1;

        ctrl             = '0;
        ctrl.ram_waddr   = head_reg;
        ctrl.ram_raddr   = ptr_reg;
        ctrl.res_entries = count_reg;

        unique case (state_reg)
            ssrb_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.cap = 1'b1;
                    ptr_next = tail_reg;
                    iss_next = '0;
                    chk_next = '0;
                    // remove from an empty ring answers at once
                    if (func == ssrb_pkg::FUNC_REMOVE && count_reg == '0)
                    begin
                        ctrl.res_vld = 1'b1;
                    end
                end
            end
            ssrb_pkg::ST_SCAN:
            begin
                if (issue)
                begin
                    ptr_next  = wrap_inc(ptr_reg);
                    iss_next  = iss_reg + 1'b1;
                    dvld_next = 1'b1;
                end
                if (dvld_reg)
                begin
                    chk_next = chk_reg + 1'b1;
                    if (close)
                    begin
                        ctrl.res_vld = 1'b1;
                    end
                end
            end
            ssrb_pkg::ST_WRITE:
            begin
                ctrl.ram_we  = 1'b1;
                ctrl.res_vld = 1'b1;
                ctrl.res_ok  = 1'b1;
                head_next    = wrap_inc(head_reg);
                if (count_reg == ssrb_pkg::LAST_IDX)
                begin
                    // full: oldest entry drops out, count stays
                    tail_next = wrap_inc(tail_reg);
                end
                else
                begin
                    count_next       = count_reg + 1'b1;
                    ctrl.res_entries = count_reg + 1'b1;
                end
            end
            ssrb_pkg::ST_READ:
            begin
            end
            ssrb_pkg::ST_POP:
            begin
                ctrl.res_vld     = 1'b1;
                ctrl.res_ok      = 1'b1;
                ctrl.res_pop     = 1'b1;
                ctrl.res_entries = count_reg - 1'b1;
                tail_next        = wrap_inc(tail_reg);
                count_next       = count_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/spaced_sample_ring_buffer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spaced_sample_ring_buffer_core
// ring buffer of calibration samples that rejects near-duplicate temperatures
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Every item gives one
// result, shown for a single cycle with done high; the receiver cannot hold
// it off, so it must capture the result in that cycle. An insert (func 0)
// walks the held temperatures oldest first through one shared distance unit
// fed by the temperature ram, one entry per cycle; it is busy through the
// scan and write states, only the write state when the ring is empty, and
// the walk ends early when a close temperature is found; done is high in
// the first cycle that busy is low again. A remove (func 1) is busy through
// its read and pop states while the ram read completes; a remove from
// an empty ring is answered without going busy, done high the next cycle.
// The spacing register may be written only while no item is in flight.
// ----------------------------------------------------------------------------
module spaced_sample_ring_buffer_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // configuration
    input  wire logic                                cfg_we,
    input  wire logic        [ssrb_pkg::SAMP_W-1:0]  cfg_data,

    // command
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                func,
    input  wire logic signed [ssrb_pkg::SAMP_W-1:0]  temp_in,
    input  wire logic signed [ssrb_pkg::SAMP_W-1:0]  accel_x_in,
    input  wire logic signed [ssrb_pkg::SAMP_W-1:0]  accel_y_in,
    input  wire logic signed [ssrb_pkg::SAMP_W-1:0]  accel_z_in,
    input  wire logic signed [ssrb_pkg::SAMP_W-1:0]  gyro_x_in,
    input  wire logic signed [ssrb_pkg::SAMP_W-1:0]  gyro_y_in,
    input  wire logic signed [ssrb_pkg::SAMP_W-1:0]  gyro_z_in,
    input  wire logic signed [ssrb_pkg::SAMP_W-1:0]  mag_x_in,
    input  wire logic signed [ssrb_pkg::SAMP_W-1:0]  mag_y_in,
    input  wire logic signed [ssrb_pkg::SAMP_W-1:0]  mag_z_in,

    // result
    output logic                                     done,
    output logic                                     ok,
    output logic             [ssrb_pkg::ENT_W-1:0]   entries,
    output logic signed      [ssrb_pkg::SAMP_W-1:0]  temp_out,
    output logic signed      [ssrb_pkg::SAMP_W-1:0]  accel_x_out,
    output logic signed      [ssrb_pkg::SAMP_W-1:0]  accel_y_out,
    output logic signed      [ssrb_pkg::SAMP_W-1:0]  accel_z_out,
    output logic signed      [ssrb_pkg::SAMP_W-1:0]  gyro_x_out,
    output logic signed      [ssrb_pkg::SAMP_W-1:0]  gyro_y_out,
    output logic signed      [ssrb_pkg::SAMP_W-1:0]  gyro_z_out,
    output logic signed      [ssrb_pkg::SAMP_W-1:0]  mag_x_out,
    output logic signed      [ssrb_pkg::SAMP_W-1:0]  mag_y_out,
    output logic signed      [ssrb_pkg::SAMP_W-1:0]  mag_z_out
);

    ssrb_pkg::ctrl_t ctrl;
    logic            close;

    // spacing register
    logic [ssrb_pkg::SAMP_W-1:0] spacing_reg;

    // captured item
    logic [ssrb_pkg::SAMP_W-1:0] temp_cap_reg;
    logic [ssrb_pkg::PAY_W-1:0]  pay_cap_reg;

    // ram read data
    logic [ssrb_pkg::SAMP_W-1:0] temp_rd;
    logic [ssrb_pkg::PAY_W-1:0]  pay_rd;

    // result register
    logic                        done_reg, done_next;
    logic                        ok_reg, ok_next;
    logic [ssrb_pkg::ENT_W-1:0]  entries_reg, entries_next;
    logic [ssrb_pkg::SAMP_W-1:0] temp_out_reg, temp_out_next;
    logic [ssrb_pkg::PAY_W-1:0]  pay_out_reg, pay_out_next;

    // entries carries the count modulo 64 whatever the depth
    logic [ssrb_pkg::IDX_W+ssrb_pkg::ENT_W-1:0] ent_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= ssrb_pkg::SPACING_RST_VAL;
        end
        else if (cfg_we)
        begin
            spacing_reg <= cfg_data;
        end
    end

    // payload packed as mag, gyro, accel from the top, each z, y, x
    always_ff @(posedge clk)
    begin
        if (ctrl.cap)
        begin
            temp_cap_reg <= temp_in;
            pay_cap_reg  <= {mag_z_in, mag_y_in, mag_x_in,
                             gyro_z_in, gyro_y_in, gyro_x_in,
                             accel_z_in, accel_y_in, accel_x_in};
        end
    end

    ssrb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .close (close),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    // temperature store, read by the scan and by a remove
    ssrb_ram #(
        .DATA_W (ssrb_pkg::SAMP_W),
        .ADDR_W (ssrb_pkg::IDX_W),
        .WORDS  (ssrb_pkg::DEPTH)
    ) u_temp_ram (
        .clk   (clk),
        .we    (ctrl.ram_we),
        .waddr (ctrl.ram_waddr),
        .wdata (temp_cap_reg),
        .raddr (ctrl.ram_raddr),
        .rdata (temp_rd)
    );

    // accel, gyro and mag store
    ssrb_ram #(
        .DATA_W (ssrb_pkg::PAY_W),
        .ADDR_W (ssrb_pkg::IDX_W),
        .WORDS  (ssrb_pkg::DEPTH)
    ) u_pay_ram (
        .clk   (clk),
        .we    (ctrl.ram_we),
        .waddr (ctrl.ram_waddr),
        .wdata (pay_cap_reg),
        .raddr (ctrl.ram_raddr),
        .rdata (pay_rd)
    );

    // one distance compare per scan cycle
    ssrb_dist u_dist (
        .temp_a  (temp_cap_reg),
        .temp_b  (temp_rd),
        .spacing (spacing_reg),
        .close   (close)
    );

    assign ent_ext = {{ssrb_pkg::ENT_W{1'b0}}, ctrl.res_entries};

    always_comb
    begin
        done_next     = ctrl.res_vld;
        ok_next       = ok_reg;
        entries_next  = entries_reg;
        temp_out_next = temp_out_reg;
        pay_out_next  = pay_out_reg;
        if (ctrl.res_vld)
        begin
            ok_next      = ctrl.res_ok;
            entries_next = ent_ext[ssrb_pkg::ENT_W-1:0];
            // sample fields only carry data for a successful remove
            if (ctrl.res_pop)
            begin
                temp_out_next = temp_rd;
                pay_out_next  = pay_rd;
            end
            else
            begin
                temp_out_next = '0;
                pay_out_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg       <= ok_next;
        entries_reg  <= entries_next;
        temp_out_reg <= temp_out_next;
        pay_out_reg  <= pay_out_next;
    end

    assign done        = done_reg;
    assign ok          = ok_reg;
    assign entries     = entries_reg;
    assign temp_out    = temp_out_reg;
    assign accel_x_out = pay_out_reg[0*ssrb_pkg::SAMP_W +: ssrb_pkg::SAMP_W];
    assign accel_y_out = pay_out_reg[1*ssrb_pkg::SAMP_W +: ssrb_pkg::SAMP_W];
    assign accel_z_out = pay_out_reg[2*ssrb_pkg::SAMP_W +: ssrb_pkg::SAMP_W];
    assign gyro_x_out  = pay_out_reg[3*ssrb_pkg::SAMP_W +: ssrb_pkg::SAMP_W];
    assign gyro_y_out  = pay_out_reg[4*ssrb_pkg::SAMP_W +: ssrb_pkg::SAMP_W];
    assign gyro_z_out  = pay_out_reg[5*ssrb_pkg::SAMP_W +: ssrb_pkg::SAMP_W];
    assign mag_x_out   = pay_out_reg[6*ssrb_pkg::SAMP_W +: ssrb_pkg::SAMP_W];
    assign mag_y_out   = pay_out_reg[7*ssrb_pkg::SAMP_W +: ssrb_pkg::SAMP_W];
    assign mag_z_out   = pay_out_reg[8*ssrb_pkg::SAMP_W +: ssrb_pkg::SAMP_W];

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the spaced sample ring buffer core
// ----------------------------------------------------------------------------
// Items go in over the start/busy handshake. Each accepted item is run
// through a local model of the ring, which holds its own copy of the held
// samples and of the spacing register. Each result strobed by done is then
// checked field by field against the oldest predicted result. Directed
// items cover the bounds first. Random phases at several spacing values
// follow, with near-duplicate temperatures mixed in.
// ----------------------------------------------------------------------------
module tb;

    // one sample, lane 0 is temperature, then accel xyz, gyro xyz, mag xyz
    typedef logic [9:0][ssrb_pkg::SAMP_W-1:0] sample_t;

    typedef struct packed {
        logic                       ok;
        logic [ssrb_pkg::ENT_W-1:0] entries;
        sample_t                    data;
    } pop_result_t;

    localparam int WATCHDOG_LIMIT = 4000;

    // clock and reset, inputs known from time zero
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic                        cfg_we   = 1'b0;
    logic [ssrb_pkg::SAMP_W-1:0] cfg_data = '0;
    logic                        start    = 1'b0;
    logic                        op_sel   = ssrb_pkg::FUNC_INSERT;
    sample_t                     drv_sample = '0;

    logic                        busy;
    logic                        done;
    logic                        ok;
    logic [ssrb_pkg::ENT_W-1:0]  entries;
    logic signed [ssrb_pkg::SAMP_W-1:0] temp_out;
    logic signed [ssrb_pkg::SAMP_W-1:0] accel_x_out, accel_y_out, accel_z_out;
    logic signed [ssrb_pkg::SAMP_W-1:0] gyro_x_out, gyro_y_out, gyro_z_out;
    logic signed [ssrb_pkg::SAMP_W-1:0] mag_x_out, mag_y_out, mag_z_out;
    sample_t                     seen_sample;

    assign seen_sample = {mag_z_out, mag_y_out, mag_x_out,
                          gyro_z_out, gyro_y_out, gyro_x_out,
                          accel_z_out, accel_y_out, accel_x_out, temp_out};

    spaced_sample_ring_buffer_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .func        (op_sel),
        .temp_in     (drv_sample[0]),
        .accel_x_in  (drv_sample[1]),
        .accel_y_in  (drv_sample[2]),
        .accel_z_in  (drv_sample[3]),
        .gyro_x_in   (drv_sample[4]),
        .gyro_y_in   (drv_sample[5]),
        .gyro_z_in   (drv_sample[6]),
        .mag_x_in    (drv_sample[7]),
        .mag_y_in    (drv_sample[8]),
        .mag_z_in    (drv_sample[9]),
        .done        (done),
        .ok          (ok),
        .entries     (entries),
        .temp_out    (temp_out),
        .accel_x_out (accel_x_out),
        .accel_y_out (accel_y_out),
        .accel_z_out (accel_z_out),
        .gyro_x_out  (gyro_x_out),
        .gyro_y_out  (gyro_y_out),
        .gyro_z_out  (gyro_z_out),
        .mag_x_out   (mag_x_out),
        .mag_y_out   (mag_y_out),
        .mag_z_out   (mag_z_out)
    );

    // ------------------------------------------------------------------------
    // local copy of the ring and its spacing register
    // ------------------------------------------------------------------------
    sample_t     ring_mem [ssrb_pkg::DEPTH];
    int          ring_head   = 0;
    int          ring_tail   = 0;
    int          ring_count  = 0;
    int          spacing_reg = int'(ssrb_pkg::SPACING_RST_VAL);

    pop_result_t pending_results [$];
    int          fail_cnt  = 0;
    bit          idle_en   = 1'b1;
    int          quiet_cycles = 0;

    string field_name [10] = '{"temp_out", "accel_x_out", "accel_y_out", "accel_z_out",
                               "gyro_x_out", "gyro_y_out", "gyro_z_out",
                               "mag_x_out", "mag_y_out", "mag_z_out"};

    // apply one item to the local ring and return what the core should report
    function automatic pop_result_t ring_apply(input logic op, input sample_t s);
        pop_result_t r;
        int          idx;
        int          gap;
        int          k;
        bit          too_close;
        r = '0;
        if (op == ssrb_pkg::FUNC_INSERT)
        begin
            // walk held temperatures oldest first, distance is exact in int
            idx       = ring_tail;
            too_close = 1'b0;
            for (k = 0; k < ring_count; k++)
            begin
                gap = int'($signed(s[0])) - int'($signed(ring_mem[idx][0]));
                if (gap < 0)
                    gap = -gap;
                if (gap < spacing_reg)
                    too_close = 1'b1;
                idx = (idx + 1) % ssrb_pkg::DEPTH;
            end
            if (!too_close)
            begin
                ring_mem[ring_head] = s;
                ring_head  = (ring_head + 1) % ssrb_pkg::DEPTH;
                ring_count = ring_count + 1;
                // full ring drops its oldest sample straight away
                if (ring_count >= ssrb_pkg::DEPTH)
                begin
                    ring_tail  = (ring_tail + 1) % ssrb_pkg::DEPTH;
                    ring_count = ring_count - 1;
                end
                r.ok = 1'b1;
            end
        end
        else if (ring_count != 0)
        begin
            r.data     = ring_mem[ring_tail];
            ring_tail  = (ring_tail + 1) % ssrb_pkg::DEPTH;
            ring_count = ring_count - 1;
            r.ok       = 1'b1;
        end
        r.entries = ssrb_pkg::ENT_W'(ring_count);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checker: every done is matched against the oldest prediction
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int want, input int got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    endtask

    always @(posedge clk)
    begin
        pop_result_t want;
        int          i;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no item outstanding", 0, 0);
            else
            begin
                want = pending_results.pop_front();
                if (ok !== want.ok)
                    report_mismatch("ok", want.ok, ok);
                if (entries !== want.entries)
                    report_mismatch("entries", want.entries, entries);
                for (i = 0; i < 10; i++)
                    if (seen_sample[i] !== want.data[i])
                        report_mismatch(field_name[i], $signed(want.data[i]),
                                        $signed(seen_sample[i]));
            end
        end
    end

    // watchdog: too long with neither an item nor a result moving
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driving side, all tasks start and end on a falling edge
    // ------------------------------------------------------------------------

    // offer one item, hold it until taken, then predict its result
    task automatic send_item(input logic op, input sample_t s);
        if (idle_en && $urandom_range(99) < 19)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        op_sel     = op;
        drv_sample = s;
        start      = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(ring_apply(op, s));
        @(negedge clk);
        start = 1'b0;
    endtask

    // sender holds off until every outstanding result is back
    task automatic drain_results();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // register write, only called with the core idle
    task automatic write_spacing(input logic [ssrb_pkg::SAMP_W-1:0] v);
        cfg_data = v;
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we      = 1'b0;
        spacing_reg = int'(v);
    endtask

    function automatic logic [ssrb_pkg::SAMP_W-1:0] rand_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 3)
            return 16'h8000;
        if (pick < 6)
            return 16'h7fff;
        if (pick < 8)
            return 16'h0000;
        if (pick < 10)
            return 16'hffff;
        return ssrb_pkg::SAMP_W'($urandom());
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        int      i;
        for (i = 0; i < 10; i++)
            s[i] = rand_word();
        return s;
    endfunction

    // temperature right around a held one, hits both sides of the spacing edge
    function automatic logic [ssrb_pkg::SAMP_W-1:0] near_temp();
        int base;
        int off;
        int t;
        int slot;
        slot = (ring_tail + $urandom_range(ring_count - 1)) % ssrb_pkg::DEPTH;
        base = int'($signed(ring_mem[slot][0]));
        case ($urandom_range(4))
            0: off = spacing_reg;
            1: off = -spacing_reg;
            2: off = spacing_reg - 1;
            3: off = 1 - spacing_reg;
            default: off = int'($urandom_range(2 * spacing_reg)) - spacing_reg;
        endcase
        t = base + off;
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return ssrb_pkg::SAMP_W'(t);
    endfunction

    function automatic sample_t flat_sample(input logic [ssrb_pkg::SAMP_W-1:0] temp,
                                            input logic [ssrb_pkg::SAMP_W-1:0] fill);
        sample_t s;
        s    = {10{fill}};
        s[0] = temp;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // empty remove, extreme values and both sides of the default spacing
    task automatic test_empty_and_bounds();
        int k;
        send_item(ssrb_pkg::FUNC_REMOVE, '0);                              // empty ring
        send_item(ssrb_pkg::FUNC_INSERT, flat_sample(16'h8000, 16'h8000)); // most negative
        send_item(ssrb_pkg::FUNC_INSERT, flat_sample(16'h7fff, 16'h7fff)); // widest distance
        send_item(ssrb_pkg::FUNC_INSERT, flat_sample(16'h0000, 16'h0000));
        send_item(ssrb_pkg::FUNC_INSERT, flat_sample(16'd255, 16'hffff));  // one short
        send_item(ssrb_pkg::FUNC_INSERT, flat_sample(-16'sd256, 16'h5555)); // exactly spacing
        send_item(ssrb_pkg::FUNC_INSERT, flat_sample(16'd32512, 16'haaaa)); // near the top one
        for (k = 0; k < 5; k++)
            send_item(ssrb_pkg::FUNC_REMOVE, random_sample());  // last one finds it empty
    endtask

    // largest and zero spacing
    task automatic test_spacing_extremes();
        drain_results();
        write_spacing(16'hffff);
        send_item(ssrb_pkg::FUNC_INSERT, flat_sample(16'h8000, 16'h1234));
        send_item(ssrb_pkg::FUNC_INSERT, flat_sample(16'h7fff, 16'hedcb)); // 65535 passes
        send_item(ssrb_pkg::FUNC_INSERT, flat_sample(16'h0000, 16'h0f0f)); // rejected
        send_item(ssrb_pkg::FUNC_REMOVE, '0);
        send_item(ssrb_pkg::FUNC_REMOVE, '0);
        drain_results();
        write_spacing(16'h0000);
        send_item(ssrb_pkg::FUNC_INSERT, flat_sample(16'd100, 16'hf0f0));
        send_item(ssrb_pkg::FUNC_INSERT, flat_sample(16'd100, 16'h0ff0)); // duplicate accepted
        send_item(ssrb_pkg::FUNC_REMOVE, '0);
        send_item(ssrb_pkg::FUNC_REMOVE, '0);
    endtask

    // fill past the depth so the oldest sample falls out, then empty it again
    task automatic test_ring_wrap();
        int k;
        drain_results();
        write_spacing(16'd0);
        for (k = 0; k < ssrb_pkg::DEPTH + 6; k++)
            send_item(ssrb_pkg::FUNC_INSERT, random_sample());
        for (k = 0; k < ssrb_pkg::DEPTH + 2; k++)
            send_item(ssrb_pkg::FUNC_REMOVE, random_sample());
    endtask

    // one random phase: insert heavy first half, remove heavy second half
    task automatic run_phase(input logic [ssrb_pkg::SAMP_W-1:0] spacing, input int n_items,
                             input bit no_idle);
        int      k;
        int      ins_pct;
        logic    op;
        sample_t s;
        drain_results();
        write_spacing(spacing);
        idle_en = !no_idle;
        for (k = 0; k < n_items; k++)
        begin
            ins_pct = (k < n_items / 2) ? 80 : 35;
            op = ($urandom_range(99) < ins_pct) ? ssrb_pkg::FUNC_INSERT
                                                : ssrb_pkg::FUNC_REMOVE;
            s  = random_sample();
            if (op == ssrb_pkg::FUNC_INSERT && ring_count > 0 && $urandom_range(99) < 30)
                s[0] = near_temp();
            send_item(op, s);
        end
        idle_en = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_phase(ssrb_pkg::SPACING_RST_VAL, 165, 1'b0);
        run_phase(ssrb_pkg::SAMP_W'($urandom_range(1, 64)), 165, 1'b0);
        run_phase(ssrb_pkg::SAMP_W'($urandom_range(300, 1000)), 165, 1'b1); // back to back
        run_phase(16'h0000, 165, 1'b0);
        run_phase(16'hffff, 165, 1'b0);
        run_phase(ssrb_pkg::SAMP_W'($urandom_range(1000, 30000)), 165, 1'b0);
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_empty_and_bounds();
        test_spacing_extremes();
        test_ring_wrap();
        test_random_traffic();
        drain_results();
        // longest insert walk plus margin, any stray done is caught meanwhile
        repeat (ssrb_pkg::DEPTH + 8) @(negedge clk);
        if (fail_cnt == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
